FILE: design/dckv_pkg.sv
// ----------------------------------------------------------------------------
// Dual-contact key velocity scan: shared types and constants
// Word layouts of both channels, key phase codes, event codes, register
// indexes and the velocity curve constants.
// ----------------------------------------------------------------------------
package dckv_pkg;

	// Scan sample word.
	typedef struct packed {
		logic [31:0] event_time;
		logic [5:0]  key_index;
		logic        closed_contact;
		logic        open_contact;
	} scan_word_t;

	// Result word.
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  note_number;
		logic [6:0]  velocity;
		logic [3:0]  channel;
		logic        contact_fault;
		logic [31:0] glitch_count;
	} result_word_t;

	// Key phase codes as stored in the key table.
	localparam logic [1:0] PH_OFF          = 2'd0;
	localparam logic [1:0] PH_LEAVE_CLOSED = 2'd1;
	localparam logic [1:0] PH_ON           = 2'd2;
	localparam logic [1:0] PH_LEAVE_OPEN   = 2'd3;

	// Event kinds.
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_ON   = 2'd1;
	localparam logic [1:0] EV_OFF  = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] REG_MIDI_CHANNEL = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NOTE_OFFSET  = 8'd1;
	localparam int unsigned CFG_DATA_W = 7;
	localparam logic [6:0] NOTE_OFFSET_RESET = 7'd33;

	// Velocity curve.
	localparam logic [31:0] VEL_KNEE = 32'd1000;
	localparam logic [6:0]  VEL_MAX  = 7'd127;
	localparam logic [6:0]  VEL_MIN  = 7'd1;
	localparam logic [24:0] VEL_SPAN = 25'd126;

	// Key table addressing covers the largest supported key count.
	localparam int unsigned KEY_ADDR_W = 8;

	// Output queue.
	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PTR_W = 3;
	localparam int unsigned FIFO_CNT_W = 4;

	// Key table entry: phase and the time the phase began.
	typedef struct packed {
		logic [1:0]  phase;
		logic [31:0] start;
	} key_entry_t;

	// Write-back request to the key table.
	typedef struct packed {
		logic                  en;
		logic [KEY_ADDR_W-1:0] addr;
		key_entry_t            entry;
	} kt_wr_t;

endpackage

FILE: design/dckv_key_table.sv
// ----------------------------------------------------------------------------
// Dual-contact key velocity scan: per-key table
// Synchronous memory of key phase and phase start time with registered read,
// per-entry valid bits for the reset value, and forwarding of a write that
// lands on the same edge as the read.
// ----------------------------------------------------------------------------
module dckv_key_table #(
	parameter int NUM_KEYS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [dckv_pkg::KEY_ADDR_W-1:0]     rd_addr,
	input  dckv_pkg::kt_wr_t                    wr,
	output dckv_pkg::key_entry_t                rd_entry
);
	import dckv_pkg::*;

	localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	key_entry_t          mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] valid_q;
	key_entry_t          raw_s1;
	key_entry_t          fwd_s1;
	logic                vld_s1;
	logic                hit_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.entry;
		end
		if (rd_en) begin
			raw_s1 <= mem[rd_addr[AW-1:0]];
			fwd_s1 <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= valid_q[rd_addr[AW-1:0]];
				hit_s1 <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	// A write on the read edge is not yet in the memory, so it is taken from
	// the captured copy. An entry never written reads as key off at time zero.
	always_comb begin
		priority if (hit_s1) begin
			rd_entry = fwd_s1;
		end else if (vld_s1) begin
			rd_entry = raw_s1;
		end else begin
			rd_entry = '0;
		end
	end

endmodule

FILE: design/dckv_out_fifo.sv
// ----------------------------------------------------------------------------
// Dual-contact key velocity scan: result queue
// Small queue in front of the result channel that absorbs the words still in
// the pipeline while the consumer stalls.
// ----------------------------------------------------------------------------
module dckv_out_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  dckv_pkg::result_word_t             push_word,
	input  logic                               result_stall,
	output logic                               result_valid,
	output dckv_pkg::result_word_t             result_word,
	output logic [dckv_pkg::FIFO_CNT_W-1:0]    count
);
	import dckv_pkg::*;

	result_word_t            buf_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    pop;

	assign result_valid = (count_q != '0);
	assign result_word  = buf_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/dual_contact_key_velocity_scan.sv
// A result passes the stage registers and then the result queue before it is offered.
// Throughput: one scan word per cycle while scan_stall is low; the per-key table does
// one read and one write-back each cycle, with forwarding between neighboring words.
// Input stalls when the words in the pipeline plus those in the result queue reach eight.
// Reset clears the key table through per-key valid bits at once, with no
// clearing pass; registers return to channel 0 and note offset 33.
// ----------------------------------------------------------------------------
// Dual-contact key velocity scan
// Tracks the contact phase of every key, emits note-on with a velocity from
// the contact transit time, note-off, and counts contact glitches.
// ----------------------------------------------------------------------------
module dual_contact_key_velocity_scan #(
	parameter int NUM_KEYS = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   scan_valid,
	output logic                                   scan_stall,
	input  dckv_pkg::scan_word_t                   scan_word,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output dckv_pkg::result_word_t                 result_word,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dckv_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [dckv_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import dckv_pkg::*;

	localparam logic [KEY_ADDR_W:0] KeyLimit = (KEY_ADDR_W + 1)'(NUM_KEYS);

	// Configuration.
	logic [3:0] midi_channel_q;
	logic [6:0] note_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= '0;
			note_offset_q  <= NOTE_OFFSET_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIDI_CHANNEL: midi_channel_q <= cfg_data[3:0];
				REG_NOTE_OFFSET:  note_offset_q  <= cfg_data[6:0];
				default:          ;
			endcase
		end
	end

	// Stage valids and queue fill, for the input stall.
	logic                  v_s1, v_s2, v_s3;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W:0]   occupancy;
	logic                  accept;

	assign occupancy  = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(v_s1)
		+ (FIFO_CNT_W + 1)'(v_s2) + (FIFO_CNT_W + 1)'(v_s3);
	assign scan_stall = (occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign accept     = scan_valid && !scan_stall;

	// Stage 1: table read in flight, sample captured.
	scan_word_t scan_s1;
	key_entry_t entry_s1;
	kt_wr_t     wr;

	always_ff @(posedge clk) begin
		if (accept) begin
			scan_s1 <= scan_word;
		end
	end

	dckv_key_table #(
		.NUM_KEYS(NUM_KEYS)
	) u_key_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (KEY_ADDR_W'(scan_word.key_index)),
		.wr       (wr),
		.rd_entry (entry_s1)
	);

	// Stage 1 logic: phase update and write-back.
	logic        in_range;
	logic [1:0]  ph;
	logic [1:0]  next_ph;
	logic        refresh;
	logic [1:0]  kind;
	logic        fault;
	logic        g_inc;
	logic [31:0] glitch_q;
	logic [31:0] glitch_next;
	logic [31:0] elapsed;
	logic [7:0]  note;

	assign in_range = ((KEY_ADDR_W + 1)'(scan_s1.key_index) < KeyLimit);
	assign ph       = entry_s1.phase;
	assign elapsed  = scan_s1.event_time - entry_s1.start;
	assign note     = 8'(scan_s1.key_index) + 8'(note_offset_q);

	always_comb begin
		next_ph = ph;
		refresh = 1'b1;
		kind    = EV_NONE;
		fault   = 1'b0;
		g_inc   = 1'b0;
		priority if (scan_s1.closed_contact && scan_s1.open_contact) begin
			g_inc   = 1'b1;
			fault   = 1'b1;
			refresh = 1'b0;
		end else if (scan_s1.closed_contact) begin
			if (ph == PH_ON || ph == PH_LEAVE_OPEN) begin
				// Closed contact straight from on is a rapid release.
				g_inc = (ph == PH_ON);
				kind  = EV_OFF;
			end
			next_ph = PH_OFF;
		end else if (scan_s1.open_contact) begin
			if (ph == PH_OFF || ph == PH_LEAVE_CLOSED) begin
				// Open contact straight from off is a rapid strike.
				g_inc = (ph == PH_OFF);
				kind  = EV_ON;
			end
			next_ph = PH_ON;
		end else begin
			priority if (ph == PH_OFF) begin
				next_ph = PH_LEAVE_CLOSED;
			end else if (ph == PH_ON) begin
				next_ph = PH_LEAVE_OPEN;
			end else begin
				refresh = 1'b0;
			end
		end
		if (!in_range) begin
			kind  = EV_NONE;
			fault = 1'b0;
			g_inc = 1'b0;
		end
	end

	assign glitch_next = glitch_q + 32'(v_s1 && g_inc);

	always_comb begin
		wr.en          = v_s1 && in_range;
		wr.addr        = KEY_ADDR_W'(scan_s1.key_index);
		wr.entry.phase = next_ph;
		wr.entry.start = refresh ? scan_s1.event_time : entry_s1.start;
	end

	// Stage 2 and 3 registers.
	result_word_t res_s2, res_s3;
	logic [31:0]  elapsed_s2;
	logic [31:0]  over_s3;
	logic         fast_s3;

	always_ff @(posedge clk) begin
		res_s2.event_kind    <= kind;
		res_s2.note_number   <= note;
		res_s2.velocity      <= '0;
		res_s2.channel       <= midi_channel_q;
		res_s2.contact_fault <= fault;
		res_s2.glitch_count  <= glitch_next;
		elapsed_s2           <= elapsed;

		res_s3  <= res_s2;
		fast_s3 <= (elapsed_s2 <= VEL_KNEE);
		over_s3 <= elapsed_s2 - VEL_KNEE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			glitch_q <= '0;
		end else begin
			v_s1     <= accept;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			glitch_q <= glitch_next;
		end
	end

	// Stage 3: velocity from transit time beyond the knee.
	logic [24:0]  slow_sum;
	logic [6:0]   vel;
	result_word_t push_word;

	assign slow_sum = 25'(over_s3[31:10]) + 25'(over_s3[31:8]);

	always_comb begin
		priority if (fast_s3) begin
			vel = VEL_MAX;
		end else if (slow_sum >= VEL_SPAN) begin
			vel = VEL_MIN;
		end else begin
			vel = VEL_MAX - slow_sum[6:0];
		end
		push_word          = res_s3;
		push_word.velocity = (res_s3.event_kind == EV_ON) ? vel : 7'd0;
	end

	dckv_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (v_s3),
		.push_word    (push_word),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_word  (result_word),
		.count        (fifo_count)
	);

endmodule
